@@ rtl/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// shared types and constants of the bilinear pixel sampler
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int NumChan = 3;
	localparam int ChanW   = 8;
	localparam int FracW   = 8;
	localparam int LaneW   = 16;
	localparam int AccW    = 24;
	localparam int PixW    = NumChan * ChanW;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 10;

	typedef logic [PixW-1:0]                  pixel_t;
	typedef logic [FracW-1:0]                 frac_t;
	typedef logic [NumChan-1:0][LaneW-1:0]    lane_vec_t;
	typedef logic [NumChan-1:0][AccW-1:0]     acc_vec_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_VALID  = 2'd2;

	localparam logic [9:0] ImageWidthRst  = 10'd640;
	localparam logic [8:0] ImageHeightRst = 9'd480;

	// red in lane 0, green in lane 1, blue in lane 2
	function automatic lane_vec_t pix_lanes(pixel_t pix);
		lane_vec_t lanes;
		for (int k = 0; k < NumChan; k++) begin
			lanes[k] = LaneW'(pix[PixW-1-ChanW*k -: ChanW]);
		end
		return lanes;
	endfunction

endpackage

@@ rtl/bilinear_pixel_sampler_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_top
// rgb frame store with bilinear sampling at 8-bit fractional coordinates
// ----------------------------------------------------------------------------
// A write transaction (opcode 0) stores one pixel and keeps busy high through
// the base and write states, after which the next start is taken. A sample
// transaction (opcode 1) raises done for one cycle, after the neighbour reads
// and the blends, with red, green and blue valid in that cycle; the next start
// can be taken in the cycle after done. The length of a sample is set
// by the single-ported frame memory, which gives the four neighbours one read
// per cycle, and by the one three-lane blend unit, used for the two vertical
// blends and then the horizontal one. done is not held off: the receiver must
// take the result in the cycle it is shown. Pixels never written read back
// as undefined. Configuration writes are taken at any time with cfg_ready
// high, and must only be made while busy is low.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_top #(
	parameter int unsigned MAX_WIDTH  = 640,
	parameter int unsigned MAX_HEIGHT = 480
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [17:0]                   coord_x,
	input  logic [16:0]                   coord_y,
	input  logic [7:0]                    write_red,
	input  logic [7:0]                    write_green,
	input  logic [7:0]                    write_blue,
	output logic                          done,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bps_pkg::CfgDataW-1:0]  cfg_data
);
	import bps_pkg::*;

	localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int          AddrW = $clog2(Depth);
	localparam logic [AddrW-1:0] RowStep = AddrW'(MAX_WIDTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BASE,
		S_WRITE,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_LEFT,
		S_RIGHT,
		S_SUM,
		S_OUT
	} state_t;

	state_t            state_q;

	logic [9:0]        image_width_q;
	logic [8:0]        image_height_q;
	logic              image_valid_q;

	logic              op_q;
	logic [9:0]        ix_q;
	logic [8:0]        iy_q;
	frac_t             fx_q;
	frac_t             fy_q;
	pixel_t            wr_pix_q;

	logic [AddrW-1:0]  base_q;
	logic [3:0]        nb_ok_q;
	logic              wr_ok_q;

	pixel_t            mem [Depth];
	pixel_t            rdata_q;
	logic [AddrW-1:0]  mem_off;
	logic [AddrW-1:0]  mem_addr;
	logic              mem_we;
	logic              mem_re;

	pixel_t            p0_q;
	pixel_t            p1_q;
	pixel_t            p2_q;
	pixel_t            p3_q;
	lane_vec_t         left_q;
	lane_vec_t         right_lanes;

	lane_vec_t         op_a;
	lane_vec_t         op_b;
	frac_t             op_f;
	acc_vec_t          acc_q;

	logic [9:0]        w_eff;
	logic [8:0]        h_eff;
	logic              x0_ok;
	logic              x1_ok;
	logic              y0_ok;
	logic              y1_ok;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= ImageWidthRst;
			image_height_q <= ImageHeightRst;
			image_valid_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[9:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[8:0];
				REG_IMAGE_VALID:  image_valid_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (start) state_q <= S_BASE;
				S_BASE:  state_q <= (op_q == OP_WRITE) ? S_WRITE : S_RD0;
				S_WRITE: state_q <= S_IDLE;
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_RD3;
				S_RD3:   state_q <= S_LEFT;
				S_LEFT:  state_q <= S_RIGHT;
				S_RIGHT: state_q <= S_SUM;
				S_SUM:   state_q <= S_OUT;
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = (state_q == S_OUT);
	assign red   = acc_q[0][AccW-1 -: ChanW];
	assign green = acc_q[1][AccW-1 -: ChanW];
	assign blue  = acc_q[2][AccW-1 -: ChanW];

	// bounds against the active size clipped to the store
	always_comb begin
		w_eff = (32'(image_width_q) < 32'(MAX_WIDTH)) ? image_width_q : 10'(MAX_WIDTH);
		h_eff = (32'(image_height_q) < 32'(MAX_HEIGHT)) ? image_height_q : 9'(MAX_HEIGHT);
		x0_ok = ix_q < w_eff;
		x1_ok = (11'(ix_q) + 11'd1) < 11'(w_eff);
		y0_ok = iy_q < h_eff;
		y1_ok = (10'(iy_q) + 10'd1) < 10'(h_eff);
	end

	// transaction capture and neighbour gathering
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q     <= opcode;
			ix_q     <= coord_x[17:8];
			fx_q     <= coord_x[7:0];
			iy_q     <= coord_y[16:8];
			fy_q     <= coord_y[7:0];
			wr_pix_q <= {write_red, write_green, write_blue};
		end
		if (state_q == S_BASE) begin
			base_q     <= AddrW'(iy_q) * RowStep + AddrW'(ix_q);
			wr_ok_q    <= (32'(ix_q) < 32'(MAX_WIDTH)) && (32'(iy_q) < 32'(MAX_HEIGHT));
			nb_ok_q[0] <= image_valid_q && x0_ok && y0_ok;
			nb_ok_q[1] <= image_valid_q && x1_ok && y0_ok;
			nb_ok_q[2] <= image_valid_q && x0_ok && y1_ok;
			nb_ok_q[3] <= image_valid_q && x1_ok && y1_ok;
		end
		if (state_q == S_RD1)   p0_q   <= nb_ok_q[0] ? rdata_q : '0;
		if (state_q == S_RD2)   p1_q   <= nb_ok_q[1] ? rdata_q : '0;
		if (state_q == S_RD3)   p2_q   <= nb_ok_q[2] ? rdata_q : '0;
		if (state_q == S_LEFT)  p3_q   <= nb_ok_q[3] ? rdata_q : '0;
		if (state_q == S_RIGHT) left_q <= right_lanes;
	end

	// frame store, one access per cycle
	always_comb begin
		unique case (state_q)
			S_RD1:   mem_off = AddrW'(1);
			S_RD2:   mem_off = RowStep;
			S_RD3:   mem_off = RowStep + AddrW'(1);
			default: mem_off = '0;
		endcase
		mem_addr = base_q + mem_off;
		mem_we   = (state_q == S_WRITE) && wr_ok_q;
		unique case (state_q)
			S_RD0:   mem_re = nb_ok_q[0];
			S_RD1:   mem_re = nb_ok_q[1];
			S_RD2:   mem_re = nb_ok_q[2];
			S_RD3:   mem_re = nb_ok_q[3];
			default: mem_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= wr_pix_q;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	// blend operands: two vertical passes then one horizontal
	always_comb begin
		for (int k = 0; k < NumChan; k++) begin
			right_lanes[k] = acc_q[k][LaneW-1:0];
		end
		unique case (state_q)
			S_LEFT: begin
				op_a = pix_lanes(p0_q);
				op_b = pix_lanes(p2_q);
				op_f = fy_q;
			end
			S_RIGHT: begin
				op_a = pix_lanes(p1_q);
				op_b = pix_lanes(p3_q);
				op_f = fy_q;
			end
			S_SUM: begin
				op_a = left_q;
				op_b = right_lanes;
				op_f = fx_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
				op_f = '0;
			end
		endcase
	end

	bps_lerp u_lerp (
		.clk   (clk),
		.a     (op_a),
		.b     (op_b),
		.f     (op_f),
		.acc_q (acc_q)
	);

endmodule

@@ rtl/bps_lerp.sv @@
// ----------------------------------------------------------------------------
// bps_lerp
// three-lane weighted blend a*(256-f) + b*f with registered result
// ----------------------------------------------------------------------------
module bps_lerp (
	input  logic               clk,
	input  bps_pkg::lane_vec_t a,
	input  bps_pkg::lane_vec_t b,
	input  bps_pkg::frac_t     f,
	output bps_pkg::acc_vec_t  acc_q
);
	import bps_pkg::*;

	localparam int WgtW  = FracW + 1;
	localparam int ProdW = LaneW + WgtW;

	logic [WgtW-1:0]  wa;
	logic [WgtW-1:0]  wb;
	logic [NumChan-1:0][ProdW-1:0] pa;
	logic [NumChan-1:0][ProdW-1:0] pb;
	acc_vec_t         acc_d;

	always_comb begin
		wb = WgtW'(f);
		wa = WgtW'(1 << FracW) - wb;
		for (int k = 0; k < NumChan; k++) begin
			pa[k]    = ProdW'(a[k]) * ProdW'(wa);
			pb[k]    = ProdW'(b[k]) * ProdW'(wb);
			acc_d[k] = AccW'(pa[k] + pb[k]);
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bilinear pixel sampler
// ----------------------------------------------------------------------------
// A directed table covers reset behaviour, fraction extremes, the corners of
// the frame store, ignored writes and the degenerate register settings. It is
// followed by random pixel writes and samples under eight register settings.
// Before every random sample, any neighbour inside the active area that has
// not been written yet is filled first. Expected colours come from a local
// mirror of the frame store and the registers. The sender idles at random in
// some phases. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bps_pkg::*;

	localparam int MAX_W = 640;
	localparam int MAX_H = 480;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int NUM_PHASES = 8;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// data is the written colour, the expected colour or the register value
	typedef struct packed {
		row_kind_t            kind;
		op_t                  op;
		logic [17:0]          cx;
		logic [16:0]          cy;
		logic [23:0]          data;
		logic                 typed;
		logic [CfgIdxW-1:0]   reg_idx;
	} stim_row_t;

	localparam stim_row_t PLAN [31] = '{
		'{ROW_ITEM, OP_SAMPLE, 18'h00000, 17'h00000, 24'h000000, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h3FFFF, 17'h1FFFF, 24'h000000, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd1,      1'b0, REG_IMAGE_VALID},
		'{ROW_ITEM, OP_WRITE,  18'h00000, 17'h00000, 24'hFFFFFF, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_WRITE,  18'h00100, 17'h00000, 24'h123456, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_WRITE,  18'h00000, 17'h00100, 24'hABCDEF, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_WRITE,  18'h00100, 17'h00100, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h00000, 17'h00000, 24'hFFFFFF, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h000FF, 17'h000FF, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h00080, 17'h00000, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h00000, 17'h00040, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_WRITE,  18'h27F00, 17'h1DF00, 24'h804020, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h27F00, 17'h1DF00, 24'h804020, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h27FFF, 17'h1DFFF, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_WRITE,  18'h3FFFF, 17'h1FFFF, 24'h112233, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h3FFFF, 17'h1FFFF, 24'h000000, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_WRITE,  18'h00000, 17'h00000, 24'h00FF00, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h0007F, 17'h000C0, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd0,      1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h00000, 17'h00000, 24'h000000, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd1,      1'b0, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd1,      1'b0, REG_IMAGE_HEIGHT},
		'{ROW_ITEM, OP_SAMPLE, 18'h000FF, 17'h000FF, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd1023,   1'b0, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd511,    1'b0, REG_IMAGE_HEIGHT},
		'{ROW_ITEM, OP_SAMPLE, 18'h27F80, 17'h1DF80, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_ITEM, OP_SAMPLE, 18'h000C0, 17'h00010, 24'h000000, 1'b0, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd0,      1'b0, REG_IMAGE_HEIGHT},
		'{ROW_ITEM, OP_SAMPLE, 18'h00000, 17'h00000, 24'h000000, 1'b1, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd640,    1'b0, REG_IMAGE_WIDTH},
		'{ROW_CFG,  OP_WRITE,  18'h00000, 17'h00000, 24'd480,    1'b0, REG_IMAGE_HEIGHT}
	};

	localparam logic [9:0] PHASE_WIDTH  [NUM_PHASES] = '{640, 1, 1023, 17, 0, 5, 640, 300};
	localparam logic [8:0] PHASE_HEIGHT [NUM_PHASES] = '{480, 1, 511, 9, 5, 0, 480, 200};
	localparam logic       PHASE_VALID  [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 opcode;
	logic [17:0]          coord_x;
	logic [16:0]          coord_y;
	logic [7:0]           write_red;
	logic [7:0]           write_green;
	logic [7:0]           write_blue;
	logic                 done;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	colour_t     frame_mirror  [MAX_W*MAX_H];
	bit          pixel_written [MAX_W*MAX_H];
	logic [9:0]  img_width;
	logic [8:0]  img_height;
	logic        image_on;

	colour_t     colour_queue [$];
	int          idle_pct;
	int          n_items;
	int          n_writes;
	int          n_samples;
	int          n_settings;
	int          n_checked;
	int          n_errors;
	int          cycle_count;

	bilinear_pixel_sampler_top #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.write_red   (write_red),
		.write_green (write_green),
		.write_blue  (write_blue),
		.done        (done),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned span_x();
		return (img_width < MAX_W) ? img_width : MAX_W;
	endfunction

	function automatic int unsigned span_y();
		return (img_height < MAX_H) ? img_height : MAX_H;
	endfunction

	function automatic bit in_frame(int unsigned px, int unsigned py);
		return px < span_x() && py < span_y();
	endfunction

	function automatic logic [7:0] lerp2d(int unsigned c0, int unsigned c1, int unsigned c2,
			int unsigned c3, int unsigned fx, int unsigned fy);
		int unsigned left;
		int unsigned right;
		int unsigned sum;
		left  = fy * c2 + (256 - fy) * c0;
		right = fy * c3 + (256 - fy) * c1;
		sum   = fx * right + (256 - fx) * left;
		return 8'(sum >> 16);
	endfunction

	function automatic colour_t bilinear_blend(logic [17:0] cx, logic [16:0] cy);
		int unsigned ix;
		int unsigned iy;
		int unsigned px;
		int unsigned py;
		colour_t     nb [4];
		colour_t     res;
		if (!image_on)
			return '0;
		ix = cx[17:8];
		iy = cy[16:8];
		// top-left, top-right, bottom-left, bottom-right
		for (int k = 0; k < 4; k++) begin
			px = ix + k % 2;
			py = iy + k / 2;
			nb[k] = in_frame(px, py) ? frame_mirror[py*MAX_W+px] : colour_t'('0);
		end
		res.red   = lerp2d(nb[0].red, nb[1].red, nb[2].red, nb[3].red, cx[7:0], cy[7:0]);
		res.green = lerp2d(nb[0].green, nb[1].green, nb[2].green, nb[3].green,
			cx[7:0], cy[7:0]);
		res.blue  = lerp2d(nb[0].blue, nb[1].blue, nb[2].blue, nb[3].blue, cx[7:0], cy[7:0]);
		return res;
	endfunction

	function automatic logic [7:0] pick_fraction();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic flag_error(string msg);
		n_errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(op_t op, logic [17:0] cx, logic [16:0] cy, colour_t data,
			bit typed);
		int unsigned px;
		int unsigned py;
		start       <= 1'b1;
		opcode      <= op;
		coord_x     <= cx;
		coord_y     <= cy;
		write_red   <= data.red;
		write_green <= data.green;
		write_blue  <= data.blue;
		do @(posedge clk); while (busy);
		if (op == OP_WRITE) begin
			px = cx[17:8];
			py = cy[16:8];
			if (px < MAX_W && py < MAX_H) begin
				frame_mirror[py*MAX_W+px]  = data;
				pixel_written[py*MAX_W+px] = 1'b1;
				n_items++;
			end
			n_writes++;
		end else begin
			colour_queue.push_back(typed ? data : bilinear_blend(cx, cy));
			n_samples++;
			n_items++;
		end
		@(negedge clk);
	endtask

	task automatic sender_pause();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (colour_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMAGE_WIDTH: begin
				img_width = val[9:0];
			end
			REG_IMAGE_HEIGHT: begin
				img_height = val[8:0];
			end
			REG_IMAGE_VALID: begin
				image_on = val[0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// write any unwritten neighbour inside the active area before a sample
	task automatic fill_neighbours(logic [17:0] cx, logic [16:0] cy);
		int unsigned px;
		int unsigned py;
		for (int k = 0; k < 4; k++) begin
			px = cx[17:8] + k % 2;
			py = cy[16:8] + k / 2;
			if (in_frame(px, py) && !pixel_written[py*MAX_W+px]) begin
				send_item(OP_WRITE, {px[9:0], pick_fraction()}, {py[8:0], pick_fraction()},
					colour_t'(24'($urandom)), 1'b0);
				sender_pause();
			end
		end
	endtask

	task automatic random_phase(int target);
		int          ix;
		int          iy;
		int unsigned zone;
		logic [17:0] cx;
		logic [16:0] cy;
		while (n_items < target) begin
			zone = $urandom_range(99);
			if (zone < 20) begin
				if ($urandom_range(1)) begin
					cx = {10'($urandom_range(12)), pick_fraction()};
					cy = {9'($urandom_range(12)), pick_fraction()};
				end else begin
					cx = 18'($urandom);
					cy = 17'($urandom);
				end
				send_item(OP_WRITE, cx, cy, colour_t'(24'($urandom)), 1'b0);
			end else begin
				if (zone < 55) begin
					ix = $urandom_range(12);
					iy = $urandom_range(12);
				end else if (zone < 72) begin
					ix = int'(span_x()) - 2 + int'($urandom_range(2));
					iy = int'(span_y()) - 2 + int'($urandom_range(2));
				end else if (zone < 84) begin
					ix = $urandom_range(636, 641);
					iy = $urandom_range(476, 481);
				end else begin
					ix = $urandom_range(1023);
					iy = $urandom_range(511);
				end
				if (ix < 0)
					ix = 0;
				if (iy < 0)
					iy = 0;
				cx = {ix[9:0], pick_fraction()};
				cy = {iy[8:0], pick_fraction()};
				fill_neighbours(cx, cy);
				send_item(OP_SAMPLE, cx, cy, '0, 1'b0);
			end
			sender_pause();
		end
	endtask

	always @(posedge clk) begin : result_check
		colour_t want;
		if (arst_n && done) begin
			if (colour_queue.size() == 0) begin
				flag_error($sformatf("result %h %h %h with no transaction outstanding",
					red, green, blue));
			end else begin
				want = colour_queue.pop_front();
				n_checked++;
				if (red !== want.red)
					flag_error($sformatf("red %h, expected %h", red, want.red));
				if (green !== want.green)
					flag_error($sformatf("green %h, expected %h", green, want.green));
				if (blue !== want.blue)
					flag_error($sformatf("blue %h, expected %h", blue, want.blue));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			colour_queue.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = OP_WRITE;
		coord_x     = '0;
		coord_y     = '0;
		write_red   = '0;
		write_green = '0;
		write_blue  = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_IMAGE_WIDTH;
		cfg_data    = '0;
		img_width   = ImageWidthRst;
		img_height  = ImageHeightRst;
		image_on    = 1'b0;
		idle_pct    = 0;
		n_items     = 0;
		n_writes    = 0;
		n_samples   = 0;
		n_settings  = 1;
		n_checked   = 0;
		n_errors    = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				wait_idle();
				write_register(PLAN[i].reg_idx, PLAN[i].data[CfgDataW-1:0]);
				n_settings++;
			end else begin
				send_item(PLAN[i].op, PLAN[i].cx, PLAN[i].cy, PLAN[i].data, PLAN[i].typed);
			end
		end

		// sender idle per phase in turn: none, about two in three, none, about one in five
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_register(REG_IMAGE_WIDTH, PHASE_WIDTH[p]);
			write_register(REG_IMAGE_HEIGHT, CfgDataW'(PHASE_HEIGHT[p]));
			write_register(REG_IMAGE_VALID, CfgDataW'(PHASE_VALID[p]));
			n_settings++;
			idle_pct = (p % 4 == 1) ? 67 : ((p % 4 == 3) ? 22 : 0);
			random_phase(n_items + ITEMS_PER_PHASE);
		end
		wait_idle();

		$display("covered %0d pixel writes and %0d samples under %0d register settings",
			n_writes, n_samples, n_settings);
		$display("%0d colours compared, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && colour_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bps_pkg.sv
rtl/bps_lerp.sv
rtl/bilinear_pixel_sampler_top.sv
bench/testbench.sv
